>>> sv/rfq_pkg.sv
// Shared constants and types for the reversible FIFO queue.
package rfq_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;

    localparam logic [1:0] REQ_ENQ   = 2'd0;
    localparam logic [1:0] REQ_DEQ   = 2'd1;
    localparam logic [1:0] REQ_REV   = 2'd2;
    localparam logic [1:0] REQ_QUERY = 2'd3;

    typedef struct packed {
        logic                     en;
        logic [IDX_W-1:0]         addr;
        logic signed [DATA_W-1:0] data;
    } wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } rd_t;

endpackage

>>> sv/rfq_ifs.sv
// Request and response channel interfaces of the reversible FIFO queue.
interface rfq_req_if;
    logic                                     valid;
    logic                                     ready;
    logic [1:0]                               req_type;
    logic signed [rfq_pkg::DATA_W-1:0]        value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface rfq_rsp_if;
    logic                                     valid;
    logic                                     ready;
    logic                                     ok;
    logic signed [rfq_pkg::DATA_W-1:0]        front_value;
    logic                                     is_empty;
    logic [rfq_pkg::COUNT_W-1:0]              count;

    modport source (output valid, output ok, output front_value, output is_empty,
                    output count, input ready);
    modport sink   (input valid, input ok, input front_value, input is_empty,
                    input count, output ready);
endinterface

>>> sv/reversible_fifo_queue_unit.sv
// Bounded queue of signed 32-bit values with constant-time reversal. Each request
// (enqueue, dequeue, reverse, query) gives one response carrying ok, the front
// value, an empty flag and the count after the request. Pointer state updates as
// the request is taken; the front value is read from the ring store over its
// single registered read port and moves with the pending result into the output
// register; with the response taken promptly, one request is accepted per cycle.
module reversible_fifo_queue_unit (
    input  logic      clk,
    input  logic      rst_n,
    rfq_req_if.sink   req,
    rfq_rsp_if.source rsp
);

    localparam int IDX_W = rfq_pkg::IDX_W;
    localparam int CNT_W = rfq_pkg::CNT_W;
    localparam logic [IDX_W:0]   DEPTH_X = (IDX_W + 1)'(rfq_pkg::DEPTH);
    localparam logic [CNT_W-1:0] FULL_C  = CNT_W'(rfq_pkg::DEPTH);

    // physical slot of the element off places from the front
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] front,
                                                 input logic [IDX_W-1:0] off,
                                                 input logic             dir);
        logic [IDX_W:0] s;
        begin
            if (!dir)
            begin
                s = {1'b0, front} + {1'b0, off};
                if (s >= DEPTH_X)
                begin
                    s = s - DEPTH_X;
                end
            end
            else if (front >= off)
            begin
                s = {1'b0, front} - {1'b0, off};
            end
            else
            begin
                s = {1'b0, front} + DEPTH_X - {1'b0, off};
            end
            return s[IDX_W-1:0];
        end
    endfunction

    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             dir_reg, dir_next;

    logic             pend_reg;
    logic             pend_ok_reg, pend_ok_next;
    logic             pend_empty_reg;
    logic [CNT_W-1:0] pend_cnt_reg;

    logic                               out_valid_reg;
    logic                               out_ok_reg;
    logic signed [rfq_pkg::DATA_W-1:0]  out_front_reg;
    logic                               out_empty_reg;
    logic [rfq_pkg::COUNT_W-1:0]        out_count_reg;

    logic             out_load, accept;
    logic [CNT_W-1:0] cnt_m1;
    rfq_pkg::wr_t     wr;
    rfq_pkg::rd_t     rd;
    logic signed [rfq_pkg::DATA_W-1:0] rd_data;

    assign out_load  = pend_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !pend_reg || out_load;
    assign accept    = req.valid && req.ready;
    assign cnt_m1    = cnt_reg - CNT_W'(1);

    always_comb
    begin
        front_next   = front_reg;
        cnt_next     = cnt_reg;
        dir_next     = dir_reg;
        pend_ok_next = 1'b1;
        wr.en        = 1'b0;
        wr.addr      = slot_of(front_reg, cnt_reg[IDX_W-1:0], dir_reg);
        wr.data      = req.value;
        case (req.req_type)
            rfq_pkg::REQ_ENQ:
            begin
                if (cnt_reg == FULL_C)
                begin
                    pend_ok_next = 1'b0;
                end
                else
                begin
                    wr.en    = accept;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            rfq_pkg::REQ_DEQ:
            begin
                if (cnt_reg == '0)
                begin
                    pend_ok_next = 1'b0;
                end
                else
                begin
                    front_next = slot_of(front_reg, IDX_W'(1), dir_reg);
                    cnt_next   = cnt_m1;
                end
            end
            rfq_pkg::REQ_REV:
            begin
                if (cnt_reg != '0)
                begin
                    front_next = slot_of(front_reg, cnt_m1[IDX_W-1:0], dir_reg);
                end
                dir_next = !dir_reg;
            end
            default:
            begin
                // query: state unchanged
            end
        endcase
        rd.en   = accept;
        rd.addr = front_next;
    end

    rfq_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            cnt_reg       <= '0;
            dir_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                front_reg <= front_next;
                cnt_reg   <= cnt_next;
                dir_reg   <= dir_next;
            end
            if (accept)
            begin
                pend_reg <= 1'b1;
            end
            else if (out_load)
            begin
                pend_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_ok_reg    <= pend_ok_next;
            pend_empty_reg <= (cnt_next == '0);
            pend_cnt_reg   <= cnt_next;
        end
        if (out_load)
        begin
            out_ok_reg    <= pend_ok_reg;
            out_front_reg <= pend_empty_reg ? '0 : rd_data;
            out_empty_reg <= pend_empty_reg;
            out_count_reg <= rfq_pkg::COUNT_W'(pend_cnt_reg);
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.ok          = out_ok_reg;
    assign rsp.front_value = out_front_reg;
    assign rsp.is_empty    = out_empty_reg;
    assign rsp.count       = out_count_reg;

endmodule

>>> sv/rfq_store.sv
// Ring store: one write and one registered read per cycle, write-through on a clash.
module rfq_store (
    input  logic                               clk,
    input  rfq_pkg::wr_t                       wr,
    input  rfq_pkg::rd_t                       rd,
    output logic signed [rfq_pkg::DATA_W-1:0]  rd_data
);

    logic signed [rfq_pkg::DATA_W-1:0] mem [rfq_pkg::DEPTH];
    logic signed [rfq_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // a read of the slot being written returns the new item
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            if (wr.en && (wr.addr == rd.addr))
            begin
                rd_data_reg <= wr.data;
            end
            else
            begin
                rd_data_reg <= mem[rd.addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule
